>>> design/conv3x3_clamp_per_channel_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depthwise 3x3 convolution block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_CLAMP_PER_CHANNEL_MACROS_SVH
`define CONV3X3_CLAMP_PER_CHANNEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C3CP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c3cp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define C3CP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c3cp assertion failed");

`endif

>>> design/c3cp_pkg.sv
// ----------------------------------------------------------------------------
// c3cp_pkg
// Types, widths and register codes shared by the convolution block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package c3cp_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int CHANNELS_DEF   = 3;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 12;
    localparam int RES_W      = 13;
    localparam int FW_W       = 11;
    localparam int CFG_DATA_W = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int TAPS       = 9;
    localparam int MAX_CH     = 3;
    localparam int OUT_COL_W  = 10;
    localparam int OUT_ROW_W  = 12;
    localparam int ONE_Q12    = 4096;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic [RES_W-1:0]           result_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_IDENTITY_CH0 = 3'd1,
        REG_COEF_BANK_0  = 3'd2,
        REG_COEF_BANK_1  = 3'd3,
        REG_COEF_BANK_2  = 3'd4,
        REG_COEF_BANK_3  = 3'd5,
        REG_COEF_BANK_4  = 3'd6,
        REG_COEF_BANK_5  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic ld_mul;
        logic ld_sum;
        logic ld_res;
    } lane_ctl_t;

endpackage

>>> design/c3cp_line_buf.sv
// ----------------------------------------------------------------------------
// c3cp_line_buf
// Two line stores holding the previous two rows, with a bypass for the
// case where consecutive pixels land on the same column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c3cp_line_buf #(
    parameter int MAX_WIDTH = c3cp_pkg::MAX_WIDTH_DEF,
    parameter int PX_W      = c3cp_pkg::CHANNELS_DEF * c3cp_pkg::SAMPLE_W,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             acc,
    input  logic [COL_W-1:0] addr,
    input  logic [PX_W-1:0]  px,
    output logic [PX_W-1:0]  top,
    output logic [PX_W-1:0]  mid
);

    logic [PX_W-1:0]  above_mem     [MAX_WIDTH];
    logic [PX_W-1:0]  two_above_mem [MAX_WIDTH];

    logic [PX_W-1:0]  mid_rd_reg;
    logic [PX_W-1:0]  top_rd_reg;
    logic [PX_W-1:0]  fwd_data_reg;
    logic             fwd_reg;
    logic             pend_reg;
    logic [COL_W-1:0] pend_addr_reg;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            above_mem[addr] <= px;
            mid_rd_reg      <= above_mem[addr];
            top_rd_reg      <= two_above_mem[addr];
            fwd_data_reg    <= mid_rd_reg;
            fwd_reg         <= pend_reg && (pend_addr_reg == addr);
        end
        if (pend_reg)
        begin
            two_above_mem[pend_addr_reg] <= mid_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
        end
        else
        begin
            pend_reg <= acc;
            if (acc)
            begin
                pend_addr_reg <= addr;
            end
        end
    end

    assign mid = mid_rd_reg;
    assign top = fwd_reg ? fwd_data_reg : top_rd_reg;

endmodule

>>> design/c3cp_lane.sv
// ----------------------------------------------------------------------------
// c3cp_lane
// One channel of the convolution: nine products, a two-level adder tree,
// rounding to Q.12 and a clamp to the range 0 to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c3cp_lane #(
    parameter int LANE = 0
) (
    input  logic                clk,
    input  c3cp_pkg::lane_ctl_t ctl,
    input  logic                identity,
    input  c3cp_pkg::sample_t   taps [c3cp_pkg::TAPS],
    input  c3cp_pkg::coef_t     coefs [c3cp_pkg::TAPS],
    output c3cp_pkg::result_t   result
);

    localparam int PROD_W = c3cp_pkg::SAMPLE_W + c3cp_pkg::COEF_W;
    localparam int PSUM_W = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 4;
    localparam int GROUPS = 3;
    localparam int FRAC_SHIFT = 8;
    localparam int ROUND_HALF = 128;

    logic signed [PROD_W-1:0] prod_reg [c3cp_pkg::TAPS];
    logic signed [PSUM_W-1:0] psum_reg [GROUPS];
    logic signed [PSUM_W-1:0] psum_next [GROUPS];
    c3cp_pkg::sample_t        center_mul_reg;
    c3cp_pkg::sample_t        center_sum_reg;
    c3cp_pkg::result_t        result_reg;
    c3cp_pkg::result_t        result_next;
    logic signed [SUM_W-1:0]  total;
    logic signed [SUM_W-1:0]  scaled;
    logic                     pass_center;

    assign pass_center = (LANE == 0) && identity;

    always_ff @(posedge clk)
    begin
        if (ctl.ld_mul)
        begin
            for (int i = 0; i < c3cp_pkg::TAPS; i++)
            begin
                prod_reg[i] <= PROD_W'(taps[i]) * PROD_W'(coefs[i]);
            end
            center_mul_reg <= taps[4];
        end
        if (ctl.ld_sum)
        begin
            psum_reg       <= psum_next;
            center_sum_reg <= center_mul_reg;
        end
        if (ctl.ld_res)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            psum_next[g] = PSUM_W'(prod_reg[3 * g]) + PSUM_W'(prod_reg[3 * g + 1])
                         + PSUM_W'(prod_reg[3 * g + 2]);
        end
    end

    always_comb
    begin
        total  = SUM_W'(psum_reg[0]) + SUM_W'(psum_reg[1]) + SUM_W'(psum_reg[2])
               + SUM_W'(ROUND_HALF);
        scaled = total >>> FRAC_SHIFT;
        if (pass_center)
        begin
            if (center_sum_reg < 0)
            begin
                result_next = '0;
            end
            else if (center_sum_reg > c3cp_pkg::ONE_Q12)
            begin
                result_next = c3cp_pkg::RES_W'(c3cp_pkg::ONE_Q12);
            end
            else
            begin
                result_next = c3cp_pkg::RES_W'(center_sum_reg);
            end
        end
        else if (scaled <= 0)
        begin
            result_next = '0;
        end
        else if (scaled > c3cp_pkg::ONE_Q12)
        begin
            result_next = c3cp_pkg::RES_W'(c3cp_pkg::ONE_Q12);
        end
        else
        begin
            result_next = c3cp_pkg::RES_W'(scaled);
        end
    end

    assign result = result_reg;

endmodule

>>> design/conv3x3_clamp_per_channel.sv
// ----------------------------------------------------------------------------
// conv3x3_clamp_per_channel
// Depthwise 3x3 convolution over a raster pixel stream with Q.12 clamp.
// ----------------------------------------------------------------------------
// The block accepts one pixel per clock cycle, sustained while out_ready
// does not stall the output, and gives one result for each interior pixel,
// one row and one column behind the input. The line store read is
// registered at the accepting edge; a result then passes the multiplier
// registers of each channel lane, the partial-sum and result registers of
// the adder tree with rounding and clamping, and the output register that
// merges the lanes. The rate is set by the line stores, which take one read
// and one write per cycle on each store.
// Border pixels update the window and line stores but give no transaction.
// Configuration must only be written while the block is idle.
`timescale 1ns / 1ps

module conv3x3_clamp_per_channel #(
    parameter int MAX_WIDTH  = c3cp_pkg::MAX_WIDTH_DEF,
    parameter int CHANNELS   = c3cp_pkg::CHANNELS_DEF,
    parameter int MAX_HEIGHT = c3cp_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [c3cp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [c3cp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [c3cp_pkg::SAMPLE_W-1:0] sample_ch0,
    input  logic signed [c3cp_pkg::SAMPLE_W-1:0] sample_ch1,
    input  logic signed [c3cp_pkg::SAMPLE_W-1:0] sample_ch2,
    input  logic                                end_of_frame,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [c3cp_pkg::RES_W-1:0]          result_ch0,
    output logic [c3cp_pkg::RES_W-1:0]          result_ch1,
    output logic [c3cp_pkg::RES_W-1:0]          result_ch2,
    output logic [c3cp_pkg::OUT_COL_W-1:0]      out_col,
    output logic [c3cp_pkg::OUT_ROW_W-1:0]      out_row,
    output logic                                last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int SW    = c3cp_pkg::SAMPLE_W;
    localparam int PX_W  = CHANNELS * SW;
    localparam int BANK5_W = 2 * c3cp_pkg::COEF_W;
    localparam int NCOEF = c3cp_pkg::MAX_CH * c3cp_pkg::TAPS;

    typedef logic [CHANNELS-1:0][SW-1:0] px_t;

    logic [c3cp_pkg::FW_W-1:0]       frame_width_reg;
    logic                            identity_reg;
    logic [c3cp_pkg::CFG_DATA_W-1:0] coef_bank_reg [5];
    logic [BANK5_W-1:0]              coef_bank5_reg;
    logic [NCOEF*c3cp_pkg::COEF_W-1:0] coef_flat;

    logic [COL_W-1:0] col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic [COL_W:0]   width_eff;
    logic             col_wrap;
    logic             produce;

    logic             acc;
    logic             mv1, mv2, mv3, mv4;
    logic             free1, free2, free3, free4, free_out;

    px_t              px;
    px_t              top;
    px_t              mid;
    px_t              col2 [3];
    px_t              window_reg [6];

    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    px_t              s1_px_reg;
    logic             s1_produce_reg;
    logic [COL_W-1:0] s1_col_reg, s2_col_reg, s3_col_reg, s4_col_reg;
    logic [ROW_W-1:0] s1_row_reg, s2_row_reg, s3_row_reg, s4_row_reg;
    logic             s1_eof_reg, s2_eof_reg, s3_eof_reg, s4_eof_reg;

    c3cp_pkg::lane_ctl_t lane_ctl;
    c3cp_pkg::sample_t   samples [c3cp_pkg::MAX_CH];
    c3cp_pkg::result_t   lane_res [c3cp_pkg::MAX_CH];

    logic                out_valid_reg;
    c3cp_pkg::result_t   out_res_reg [c3cp_pkg::MAX_CH];
    logic [c3cp_pkg::OUT_COL_W-1:0] out_col_reg;
    logic [c3cp_pkg::OUT_ROW_W-1:0] out_row_reg;
    logic                out_last_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= c3cp_pkg::FW_W'(c3cp_pkg::MAX_WIDTH_DEF);
            identity_reg    <= 1'b0;
            for (int b = 0; b < 5; b++)
            begin
                coef_bank_reg[b] <= '0;
            end
            coef_bank5_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (c3cp_pkg::cfg_reg_t'(cfg_index))
                c3cp_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[c3cp_pkg::FW_W-1:0];
                c3cp_pkg::REG_IDENTITY_CH0: identity_reg     <= cfg_data[0];
                c3cp_pkg::REG_COEF_BANK_0:  coef_bank_reg[0] <= cfg_data;
                c3cp_pkg::REG_COEF_BANK_1:  coef_bank_reg[1] <= cfg_data;
                c3cp_pkg::REG_COEF_BANK_2:  coef_bank_reg[2] <= cfg_data;
                c3cp_pkg::REG_COEF_BANK_3:  coef_bank_reg[3] <= cfg_data;
                c3cp_pkg::REG_COEF_BANK_4:  coef_bank_reg[4] <= cfg_data;
                c3cp_pkg::REG_COEF_BANK_5:  coef_bank5_reg   <= cfg_data[BANK5_W-1:0];
                default:                    identity_reg     <= identity_reg;
            endcase
        end
    end

    assign coef_flat = {coef_bank5_reg, coef_bank_reg[4], coef_bank_reg[3],
                        coef_bank_reg[2], coef_bank_reg[1], coef_bank_reg[0]};

    // Handshake and stage advance.
    assign free_out = !out_valid_reg || out_ready;
    assign mv4      = s4_valid_reg && free_out;
    assign free4    = !s4_valid_reg || mv4;
    assign mv3      = s3_valid_reg && free4;
    assign free3    = !s3_valid_reg || mv3;
    assign mv2      = s2_valid_reg && free3;
    assign free2    = !s2_valid_reg || mv2;
    assign mv1      = s1_valid_reg && free2;
    assign free1    = !s1_valid_reg || mv1;
    assign in_ready = free1;
    assign acc      = in_valid && in_ready;

    assign lane_ctl.ld_mul = mv1;
    assign lane_ctl.ld_sum = mv2;
    assign lane_ctl.ld_res = mv3;

    // Position counters.
    always_comb
    begin
        if (32'(frame_width_reg) < 3)
        begin
            width_eff = (COL_W+1)'(3);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            width_eff = (COL_W+1)'(MAX_WIDTH);
        end
        else
        begin
            width_eff = (COL_W+1)'(frame_width_reg);
        end
        col_wrap = ((COL_W+1)'(col_count_reg) + (COL_W+1)'(1)) >= width_eff;
        produce  = (32'(row_count_reg) >= 2) && (32'(col_count_reg) >= 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (acc)
        begin
            if (end_of_frame)
            begin
                col_count_reg <= '0;
                row_count_reg <= '0;
            end
            else if (col_wrap)
            begin
                col_count_reg <= '0;
                if (row_count_reg == ROW_W'(MAX_HEIGHT - 1))
                begin
                    row_count_reg <= '0;
                end
                else
                begin
                    row_count_reg <= row_count_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_count_reg <= col_count_reg + COL_W'(1);
            end
        end
    end

    assign samples[0] = sample_ch0;
    assign samples[1] = sample_ch1;
    assign samples[2] = sample_ch2;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            px[c] = samples[c];
        end
    end

    c3cp_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .PX_W      (PX_W),
        .COL_W     (COL_W)
    ) u_line_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (acc),
        .addr  (col_count_reg),
        .px    (px),
        .top   (top),
        .mid   (mid)
    );

    // Stage valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (mv1)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (mv1)
            begin
                s2_valid_reg <= s1_produce_reg;
            end
            else if (mv2)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (mv2)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (mv3)
            begin
                s3_valid_reg <= 1'b0;
            end
            if (mv3)
            begin
                s4_valid_reg <= 1'b1;
            end
            else if (mv4)
            begin
                s4_valid_reg <= 1'b0;
            end
            if (mv4)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_px_reg      <= px;
            s1_col_reg     <= col_count_reg;
            s1_row_reg     <= row_count_reg;
            s1_eof_reg     <= end_of_frame;
            s1_produce_reg <= produce;
        end
        if (mv1)
        begin
            s2_col_reg <= s1_col_reg;
            s2_row_reg <= s1_row_reg;
            s2_eof_reg <= s1_eof_reg;
        end
        if (mv2)
        begin
            s3_col_reg <= s2_col_reg;
            s3_row_reg <= s2_row_reg;
            s3_eof_reg <= s2_eof_reg;
        end
        if (mv3)
        begin
            s4_col_reg <= s3_col_reg;
            s4_row_reg <= s3_row_reg;
            s4_eof_reg <= s3_eof_reg;
        end
        if (mv4)
        begin
            for (int c = 0; c < c3cp_pkg::MAX_CH; c++)
            begin
                out_res_reg[c] <= lane_res[c];
            end
            out_col_reg  <= c3cp_pkg::OUT_COL_W'(32'(s4_col_reg) - 32'd1);
            out_row_reg  <= c3cp_pkg::OUT_ROW_W'(32'(s4_row_reg) - 32'd1);
            out_last_reg <= s4_eof_reg;
        end
    end

    // Window of the two previous columns; the newest column comes from the
    // line stores and the pixel in the first stage.
    assign col2[0] = top;
    assign col2[1] = mid;
    assign col2[2] = s1_px_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (mv1)
        begin
            for (int r = 0; r < 3; r++)
            begin
                window_reg[r]     <= window_reg[3 + r];
                window_reg[3 + r] <= col2[r];
            end
        end
    end

    genvar gc;
    generate
        for (gc = 0; gc < c3cp_pkg::MAX_CH; gc++)
        begin : g_lane
            if (gc < CHANNELS)
            begin : g_used
                c3cp_pkg::sample_t taps  [c3cp_pkg::TAPS];
                c3cp_pkg::coef_t   coefs [c3cp_pkg::TAPS];

                always_comb
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        taps[3 * r]     = window_reg[r][gc];
                        taps[3 * r + 1] = window_reg[3 + r][gc];
                        taps[3 * r + 2] = col2[r][gc];
                    end
                    for (int i = 0; i < c3cp_pkg::TAPS; i++)
                    begin
                        coefs[i] = coef_flat[c3cp_pkg::COEF_W * (gc * c3cp_pkg::TAPS + i)
                                             +: c3cp_pkg::COEF_W];
                    end
                end

                c3cp_lane #(
                    .LANE (gc)
                ) u_lane (
                    .clk      (clk),
                    .ctl      (lane_ctl),
                    .identity (identity_reg),
                    .taps     (taps),
                    .coefs    (coefs),
                    .result   (lane_res[gc])
                );
            end
            else
            begin : g_unused
                assign lane_res[gc] = '0;
            end
        end
    endgenerate

    assign out_valid  = out_valid_reg;
    assign result_ch0 = out_res_reg[0];
    assign result_ch1 = out_res_reg[1];
    assign result_ch2 = out_res_reg[2];
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;
    assign last       = out_last_reg;

endmodule

>>> design/c3cp_checker.sv
// ----------------------------------------------------------------------------
// c3cp_checker
// Port-level checks for the convolution block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "conv3x3_clamp_per_channel_macros.svh"

module c3cp_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic signed [c3cp_pkg::SAMPLE_W-1:0] sample_ch0,
    input logic signed [c3cp_pkg::SAMPLE_W-1:0] sample_ch1,
    input logic signed [c3cp_pkg::SAMPLE_W-1:0] sample_ch2,
    input logic                                 end_of_frame,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [c3cp_pkg::RES_W-1:0]           result_ch0,
    input logic [c3cp_pkg::RES_W-1:0]           result_ch1,
    input logic [c3cp_pkg::RES_W-1:0]           result_ch2,
    input logic [c3cp_pkg::OUT_COL_W-1:0]       out_col,
    input logic [c3cp_pkg::OUT_ROW_W-1:0]       out_row,
    input logic                                 last
);

    // A stalled input transaction keeps its payload.
    `C3CP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
        in_valid && $stable(sample_ch0) && $stable(sample_ch1) && $stable(sample_ch2)
        && $stable(end_of_frame))

    // A stalled result transaction keeps its payload.
    `C3CP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(result_ch0) && $stable(result_ch1) && $stable(result_ch2)
        && $stable(out_col) && $stable(out_row) && $stable(last))

    // Every channel result stays within the clamp range.
    `C3CP_ASSERT_NOW(a_res_range, out_valid,
        (result_ch0 <= c3cp_pkg::RES_W'(c3cp_pkg::ONE_Q12))
        && (result_ch1 <= c3cp_pkg::RES_W'(c3cp_pkg::ONE_Q12))
        && (result_ch2 <= c3cp_pkg::RES_W'(c3cp_pkg::ONE_Q12)))

    // A result never belongs to a pixel of the first row or the first column.
    `C3CP_ASSERT_NOW(a_interior, out_valid, (out_col != '0) && (out_row != '0))

endmodule

bind conv3x3_clamp_per_channel c3cp_checker u_c3cp_checker (.*);
